[sv/tasi_pkg.sv]
// Shared types, widths and helpers for the three-axis step interpolator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tasi_pkg;

    // Width of the internal position registers.
    localparam int POS_BITS     = 16;
    // Remaining counts and step timers carry one extra bit.
    localparam int REM_BITS     = POS_BITS + 1;
    // (timer + 1) times magnitude.
    localparam int PROD_BITS    = 2 * REM_BITS + 1;
    // Fixed widths of the external fields.
    localparam int FIELD_BITS   = 16;
    localparam int NUM_AXES     = 3;
    localparam int AXIS_BITS    = $clog2(NUM_AXES);

    // Axis numbers.
    localparam logic [AXIS_BITS-1:0] AXIS_X = AXIS_BITS'(0);
    localparam logic [AXIS_BITS-1:0] AXIS_Y = AXIS_BITS'(1);
    localparam logic [AXIS_BITS-1:0] AXIS_Z = AXIS_BITS'(2);
    localparam logic [AXIS_BITS-1:0] AXIS_LAST = AXIS_BITS'(NUM_AXES - 1);

    typedef logic signed [POS_BITS-1:0]  t_pos;
    typedef logic signed [REM_BITS-1:0]  t_rem;
    typedef logic        [REM_BITS-1:0]  t_mag;
    typedef logic        [REM_BITS-1:0]  t_tmr;
    typedef logic        [REM_BITS:0]    t_tmr_p1;
    typedef logic        [PROD_BITS-1:0] t_prod;
    typedef logic        [AXIS_BITS-1:0] t_axis;

    typedef struct packed {
        logic                         mode;
        logic signed [FIELD_BITS-1:0] target_x;
        logic signed [FIELD_BITS-1:0] target_y;
        logic signed [FIELD_BITS-1:0] target_z;
        logic                         set_x;
        logic                         set_y;
        logic                         set_z;
    } t_in;

    typedef struct packed {
        logic                         step_x;
        logic                         dir_x;
        logic                         step_y;
        logic                         dir_y;
        logic                         step_z;
        logic                         dir_z;
        logic                         moving;
        logic signed [FIELD_BITS-1:0] pos_x;
        logic signed [FIELD_BITS-1:0] pos_y;
        logic signed [FIELD_BITS-1:0] pos_z;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  cap;     // capture the input item, clear step flags
        logic  load;    // apply target loads
        logic  scan;    // register the largest remaining magnitude
        logic  mul;     // multiply for the selected axis
        logic  upd;     // compare and update the selected axis
        logic  out_wr;  // write the result register
        t_axis axis;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_rem;
    } t_sts;

    function automatic t_mag mag_of(input t_rem v);
        mag_of = v[REM_BITS-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    // Low field bits of a position, sign-extended when the position is narrower.
    function automatic logic signed [FIELD_BITS-1:0] pos_field(input t_pos p);
        pos_field = FIELD_BITS'(p);
    endfunction

endpackage

`default_nettype wire

[sv/tasi_ctrl.sv]
// Controller state machine of the three-axis step interpolator.
// Depends on tasi_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tasi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_mode,
    input  wire logic           i_out_stall,
    input  wire tasi_pkg::t_sts i_sts,
    output tasi_pkg::t_cmd      o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import tasi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_SCAN = 6'b000100,
        S_MUL  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_axis  r_axis, n_axis;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // The result register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = i_in_mode ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                // A tick with nothing left to move changes nothing.
                if (i_sts.any_rem) begin
                    o_cmd.scan = 1'b1;
                    n_axis     = AXIS_X;
                    n_state    = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = t_axis'(r_axis + 1'b1);
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/tasi_dp.sv]
// Datapath of the three-axis step interpolator: axis state, shared
// multiplier, step decision and result register. Depends on tasi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tasi_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tasi_pkg::t_in  i_in_data,
    input  wire tasi_pkg::t_cmd i_cmd,
    output tasi_pkg::t_sts      o_sts,
    output tasi_pkg::t_out      o_out_data
);
    import tasi_pkg::*;

    t_in   r_in;
    t_rem  r_rem [NUM_AXES];
    t_pos  r_pos [NUM_AXES];
    t_tmr  r_tmr [NUM_AXES];
    t_mag  r_largest;
    t_prod r_prod;
    t_tmr  r_tinc;
    logic  r_step [NUM_AXES];
    logic  r_dir  [NUM_AXES];
    t_out  r_out;

    t_mag    w_mag [NUM_AXES];
    t_pos    w_tgt [NUM_AXES];
    logic    w_set [NUM_AXES];
    t_mag    w_max01;
    t_mag    w_largest;
    t_tmr    w_tmr_sel;
    t_tmr    w_tinc;
    t_tmr_p1 w_tinc_p1;
    t_prod   w_prod;
    logic    w_any_rem;
    logic    w_do_step;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_mag[a] = mag_of(r_rem[a]);
        end
    end

    // Targets are sign-extended or wrapped to the position width.
    assign w_tgt[AXIS_X] = t_pos'(r_in.target_x);
    assign w_tgt[AXIS_Y] = t_pos'(r_in.target_y);
    assign w_tgt[AXIS_Z] = t_pos'(r_in.target_z);
    assign w_set[AXIS_X] = r_in.set_x;
    assign w_set[AXIS_Y] = r_in.set_y;
    assign w_set[AXIS_Z] = r_in.set_z;

    assign w_max01   = (w_mag[AXIS_Y] > w_mag[AXIS_X]) ? w_mag[AXIS_Y] : w_mag[AXIS_X];
    assign w_largest = (w_mag[AXIS_Z] > w_max01) ? w_mag[AXIS_Z] : w_max01;
    assign w_any_rem = (r_rem[AXIS_X] != '0) || (r_rem[AXIS_Y] != '0)
                    || (r_rem[AXIS_Z] != '0);

    // The timer saturates at all ones.
    assign w_tmr_sel = r_tmr[i_cmd.axis];
    assign w_tinc    = (&w_tmr_sel) ? w_tmr_sel : t_tmr'(w_tmr_sel + 1'b1);
    assign w_tinc_p1 = t_tmr_p1'(w_tinc) + 1'b1;

    // The axis steps when timer >= largest / magnitude, which for integers
    // is the same as (timer + 1) * magnitude > largest.
    assign w_prod    = t_prod'(w_tinc_p1) * t_prod'(w_mag[i_cmd.axis]);
    assign w_do_step = (r_prod > t_prod'(r_largest));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rem[a] <= '0;
                r_pos[a] <= '0;
                r_tmr[a] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (w_set[a]) begin
                        r_rem[a] <= t_rem'(w_tgt[a]) - t_rem'(r_pos[a]);
                    end
                end
            end
            if (i_cmd.upd) begin
                if (r_rem[i_cmd.axis] == '0) begin
                    r_tmr[i_cmd.axis] <= '0;
                end else if (w_do_step) begin
                    r_tmr[i_cmd.axis] <= '0;
                    if (r_rem[i_cmd.axis][REM_BITS-1]) begin
                        r_rem[i_cmd.axis] <= r_rem[i_cmd.axis] + 1'b1;
                        r_pos[i_cmd.axis] <= r_pos[i_cmd.axis] - 1'b1;
                    end else begin
                        r_rem[i_cmd.axis] <= r_rem[i_cmd.axis] - 1'b1;
                        r_pos[i_cmd.axis] <= r_pos[i_cmd.axis] + 1'b1;
                    end
                end else begin
                    r_tmr[i_cmd.axis] <= r_tinc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_in <= i_in_data;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_step[a] <= 1'b0;
                r_dir[a]  <= 1'b0;
            end
        end
        if (i_cmd.scan) begin
            r_largest <= w_largest;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_tinc <= w_tinc;
        end
        if (i_cmd.upd && (r_rem[i_cmd.axis] != '0) && w_do_step) begin
            r_step[i_cmd.axis] <= 1'b1;
            r_dir[i_cmd.axis]  <= r_rem[i_cmd.axis][REM_BITS-1];
        end
        if (i_cmd.out_wr) begin
            r_out.step_x <= r_step[AXIS_X];
            r_out.dir_x  <= r_dir[AXIS_X];
            r_out.step_y <= r_step[AXIS_Y];
            r_out.dir_y  <= r_dir[AXIS_Y];
            r_out.step_z <= r_step[AXIS_Z];
            r_out.dir_z  <= r_dir[AXIS_Z];
            r_out.moving <= w_any_rem;
            r_out.pos_x  <= pos_field(r_pos[AXIS_X]);
            r_out.pos_y  <= pos_field(r_pos[AXIS_Y]);
            r_out.pos_z  <= pos_field(r_pos[AXIS_Z]);
        end
    end

    assign o_sts.any_rem = w_any_rem;
    assign o_out_data    = r_out;

endmodule

`default_nettype wire

[sv/three_axis_step_interpolator.sv]
// Top level of the three-axis step interpolator: joins the controller and
// the datapath. Depends on tasi_pkg, tasi_ctrl and tasi_dp.
//
//   Channel   Direction   Handshake                  Payload
//   input     in          i_in_valid / o_in_stall    i_in_data  (tasi_pkg::t_in)
//   result    out         o_out_valid / i_out_stall  o_out_data (tasi_pkg::t_out)
//
// A load item passes the load and done states; a tick passes scan, multiply and
// update per axis, and done, or just scan and done when no axis has motion left.
// Tick time is set by the single shared multiplier, serving the three axes in turn.
// Reset is synchronous and active low and zeroes positions, remaining counts
// and timers. A new item is taken only while the block is idle; a result
// waiting in the output register does not block the next transfer in.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_step_interpolator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tasi_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output tasi_pkg::t_out     o_out_data
);
    import tasi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tasi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tasi_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
